// File: hdl/dtq_pkg.sv
// types, codes and helpers shared by the deadline timer queue
package dtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_W          = 48;
    localparam int HANDLE_W        = 8;
    localparam int SCOPE_W         = 8;
    localparam int ORDER_W         = 16;
    localparam int REQ_W           = 3;
    localparam int KIND_W          = 2;

    localparam logic [REQ_W-1:0] REQ_SCHED_ABS = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SCHED_REL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADV_TO    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ADV_BY    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RESET     = 3'd5;

    localparam logic [KIND_W-1:0] EVT_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] EVT_FIRE   = 2'd1;
    localparam logic [KIND_W-1:0] EVT_REPLAY = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [TIME_W-1:0]   time_value;
        logic [HANDLE_W-1:0] handle_id;
        logic [SCOPE_W-1:0]  scope_id;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]   event_kind;
        logic [HANDLE_W-1:0] fired_handle;
        logic [TIME_W-1:0]   fired_deadline;
        logic [TIME_W-1:0]   current_time;
        logic [TIME_W-1:0]   next_deadline;
        logic                queue_empty;
        logic                dropped_full;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
        logic [SCOPE_W-1:0]  scope;
        logic [ORDER_W-1:0]  order;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

// File: hdl/deadline_timer_queue.sv
// deadline timer queue: top level with request sequencer and entry scan
//
// A request is taken when start is high and busy is low; busy then stays high
// until the request has been worked off. Results appear on result for one
// cycle each, marked by result_valid, and the final one of a request has
// result.last set. The receiver cannot hold results off.
// Every request walks the entry memory at least once: a scan reads one
// entry a cycle through the memory's single read port, and each pass ends
// in the decision state. Schedule, cancel and an advance or reset that
// removes nothing give their result after one pass; an advance makes a
// further pass for each timer it fires, and a reset one pass per replay.
// The next request may be taken in the cycle that shows the final result.
// Reset clears the current time, the insertion counter and all entry valid
// bits at once; the block takes requests in the first cycle after reset.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dtq_pkg::req_t request,
    output logic          busy,
    output logic          result_valid,
    output dtq_pkg::rsp_t result
);

    import dtq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t                   state_reg, state_next;
    logic [REQ_W-1:0]         op_reg, op_next;
    logic [SCOPE_W-1:0]       scope_reg, scope_next;
    logic [TIME_W-1:0]        now_reg, now_next;
    logic [ORDER_W-1:0]       counter_reg, counter_next;
    logic [QUEUE_DEPTH-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic                     pend_reg, pend_next;
    logic [KIND_W-1:0]        pend_kind_reg, pend_kind_next;
    logic [HANDLE_W-1:0]      pend_handle_reg, pend_handle_next;
    logic [TIME_W-1:0]        pend_dl_reg, pend_dl_next;
    logic                     pend_drop_reg, pend_drop_next;

    logic                     best_found_reg, best_found_next;
    logic [TIME_W-1:0]        best_dl_reg, best_dl_next;
    logic [ORDER_W-1:0]       best_age_reg, best_age_next;
    logic [HANDLE_W-1:0]      best_handle_reg, best_handle_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;

    rsp_t                     result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    entry_t                   ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                   rd_entry;

    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;
    logic [TIME_W-1:0]        sched_dl;
    logic [CNT_W-1:0]         cnt_prev;
    logic [IDX_W-1:0]         eval_idx;
    logic [ORDER_W-1:0]       eval_age;
    logic                     cancel_hit;
    logic                     better;
    logic                     due;
    logic [QUEUE_DEPTH-1:0]   remaining;
    logic [TIME_W-1:0]        next_dl;

    dtq_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign sched_dl   = (request.req_type == REQ_SCHED_ABS) ? request.time_value
                                                            : sat_add(now_reg, request.time_value);
    assign cnt_prev   = cnt_reg - CNT_W'(1);
    assign eval_idx   = cnt_prev[IDX_W-1:0];
    assign eval_age   = counter_reg - rd_entry.order;
    assign cancel_hit = (op_reg == REQ_CANCEL) && (scope_reg != '0)
                        && (rd_entry.scope == scope_reg);
    assign better     = !best_found_reg || (rd_entry.deadline < best_dl_reg)
                        || ((rd_entry.deadline == best_dl_reg) && (eval_age > best_age_reg));
    assign due        = best_found_reg && (best_dl_reg <= now_reg);
    assign next_dl    = best_found_reg ? best_dl_reg : {TIME_W{1'b1}};

    always_comb
    begin
        remaining               = valid_reg;
        remaining[best_idx_reg] = 1'b0;
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        scope_next        = scope_reg;
        now_next          = now_reg;
        counter_next      = counter_reg;
        valid_next        = valid_reg;
        cnt_next          = cnt_reg;
        pend_next         = pend_reg;
        pend_kind_next    = pend_kind_reg;
        pend_handle_next  = pend_handle_reg;
        pend_dl_next      = pend_dl_reg;
        pend_drop_next    = pend_drop_reg;
        best_found_next   = best_found_reg;
        best_dl_next      = best_dl_reg;
        best_age_next     = best_age_reg;
        best_handle_next  = best_handle_reg;
        best_idx_next     = best_idx_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = free_idx;
        ram_wdata.deadline = sched_dl;
        ram_wdata.handle   = request.handle_id;
        ram_wdata.scope    = request.scope_id;
        ram_wdata.order    = counter_reg;
        ram_raddr         = cnt_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next       = ST_SCAN;
                    op_next          = request.req_type;
                    scope_next       = request.scope_id;
                    cnt_next         = '0;
                    best_found_next  = 1'b0;
                    pend_next        = 1'b1;
                    pend_kind_next   = EVT_ACK;
                    pend_handle_next = '0;
                    pend_dl_next     = '0;
                    pend_drop_next   = 1'b0;
                    case (request.req_type)
                        REQ_SCHED_ABS, REQ_SCHED_REL:
                        begin
                            pend_drop_next = !free_found;
                            if (free_found)
                            begin
                                ram_we               = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                counter_next         = counter_reg + ORDER_W'(1);
                            end
                        end
                        REQ_ADV_TO:
                        begin
                            pend_next = 1'b0;
                            if (request.time_value >= now_reg)
                            begin
                                now_next = request.time_value;
                            end
                        end
                        REQ_ADV_BY:
                        begin
                            pend_next = 1'b0;
                            now_next  = sat_add(now_reg, request.time_value);
                        end
                        REQ_RESET:
                        begin
                            pend_next = 1'b0;
                            now_next  = request.time_value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if ((cnt_reg != '0) && valid_reg[eval_idx])
                begin
                    if (cancel_hit)
                    begin
                        valid_next[eval_idx] = 1'b0;
                    end
                    else if (better)
                    begin
                        best_found_next  = 1'b1;
                        best_dl_next     = rd_entry.deadline;
                        best_age_next    = eval_age;
                        best_handle_next = rd_entry.handle;
                        best_idx_next    = eval_idx;
                    end
                end
                if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                state_next      = ST_IDLE;
                cnt_next        = '0;
                best_found_next = 1'b0;
                result_next.current_time = now_reg;
                result_next.dropped_full = 1'b0;
                if (op_reg == REQ_RESET)
                begin
                    result_valid_next          = 1'b1;
                    result_next.next_deadline  = {TIME_W{1'b1}};
                    result_next.queue_empty    = 1'b1;
                    if (best_found_reg)
                    begin
                        valid_next[best_idx_reg]   = 1'b0;
                        result_next.event_kind     = EVT_REPLAY;
                        result_next.fired_handle   = best_handle_reg;
                        result_next.fired_deadline = best_dl_reg;
                        result_next.last           = (remaining == '0);
                        if (remaining != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            counter_next = '0;
                        end
                    end
                    else
                    begin
                        result_next.event_kind     = EVT_ACK;
                        result_next.fired_handle   = '0;
                        result_next.fired_deadline = '0;
                        result_next.last           = 1'b1;
                        counter_next               = '0;
                    end
                end
                else
                begin
                    result_next.event_kind     = pend_kind_reg;
                    result_next.fired_handle   = pend_handle_reg;
                    result_next.fired_deadline = pend_dl_reg;
                    result_next.dropped_full   = pend_drop_reg;
                    result_next.next_deadline  = next_dl;
                    result_next.queue_empty    = !best_found_reg;
                    result_next.last           = 1'b1;
                    result_valid_next          = pend_reg;
                    if (op_reg == REQ_ADV_TO || op_reg == REQ_ADV_BY)
                    begin
                        result_next.last = !due;
                        if (due)
                        begin
                            valid_next[best_idx_reg] = 1'b0;
                            pend_next                = 1'b1;
                            pend_kind_next           = EVT_FIRE;
                            pend_handle_next         = best_handle_reg;
                            pend_dl_next             = best_dl_reg;
                            pend_drop_next           = 1'b0;
                            state_next               = ST_SCAN;
                        end
                        else if (!pend_reg)
                        begin
                            result_valid_next          = 1'b1;
                            result_next.event_kind     = EVT_ACK;
                            result_next.fired_handle   = '0;
                            result_next.fired_deadline = '0;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            now_reg          <= '0;
            counter_reg      <= '0;
            valid_reg        <= '0;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            best_found_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            now_reg          <= now_next;
            counter_reg      <= counter_next;
            valid_reg        <= valid_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            best_found_reg   <= best_found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        scope_reg       <= scope_next;
        pend_kind_reg   <= pend_kind_next;
        pend_handle_reg <= pend_handle_next;
        pend_dl_reg     <= pend_dl_next;
        pend_drop_reg   <= pend_drop_next;
        best_dl_reg     <= best_dl_next;
        best_age_reg    <= best_age_next;
        best_handle_reg <= best_handle_next;
        best_idx_reg    <= best_idx_next;
        result_reg      <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    a_replay_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.event_kind == EVT_REPLAY) |-> result.queue_empty)
        else $error("replay result with queue not empty");

    a_drop_ack: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped_full |-> (result.event_kind == EVT_ACK))
        else $error("dropped flag on a non-acknowledge result");

    a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.event_kind == EVT_FIRE)
            |-> (result.fired_deadline <= result.current_time))
        else $error("timer fired before its deadline");

endmodule

// File: hdl/dtq_entry_ram.sv
// timer entry memory, one write port and one registered read port
module dtq_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
